### rtl/breakpoint_envelope_table_assert.svh
// Assertion helpers for the checker file.
`ifndef BREAKPOINT_ENVELOPE_TABLE_ASSERT_SVH
`define BREAKPOINT_ENVELOPE_TABLE_ASSERT_SVH

// Same-cycle implication.
`define BET_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BET_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bet_pkg.sv
package bet_pkg;

  localparam int POS_W     = 24;
  localparam int LVL_W     = 16;
  localparam int END_W     = POS_W + 1;
  localparam int REQ_W     = 2;
  localparam int IDX_W     = 8;
  localparam int CNT_OUT_W = 9;
  localparam int SPAN_W    = LVL_W + 1;
  localparam int PROD_W    = POS_W + SPAN_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_EVAL   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_APP_PL,
    ST_APP_END,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_INTERP,
    ST_RD_IDX,
    ST_RD_NEXT,
    ST_RD_FIN,
    ST_DONE
  } ctl_state_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_ACCEPT,
    DP_APP_PL,
    DP_APP_END,
    DP_SCAN,
    DP_MUL,
    DP_DIV,
    DP_INTERP,
    DP_RD_IDX,
    DP_RD_NEXT,
    DP_RD_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             full;
    logic             rd_ok;
    logic             scan_done;
    logic             scan_div;
    logic             div_last;
    logic             out_busy;
  } dp_sts_t;

endpackage

### rtl/bet_in_if.sv
interface bet_in_if;
  logic                                valid;
  logic                                ready;
  logic [bet_pkg::REQ_W-1:0]           req_type;
  logic [bet_pkg::POS_W-1:0]           pos_x;
  logic signed [bet_pkg::LVL_W-1:0]    level_in;
  logic                                has_end;
  logic [bet_pkg::POS_W-1:0]           end_in;
  logic [bet_pkg::IDX_W-1:0]           entry_index;

  modport source (output valid, req_type, pos_x, level_in, has_end, end_in, entry_index,
                  input ready);
  modport sink (input valid, req_type, pos_x, level_in, has_end, end_in, entry_index,
                output ready);
endinterface

### rtl/bet_out_if.sv
interface bet_out_if;
  logic                             valid;
  logic                             ready;
  logic                             status;
  logic signed [bet_pkg::LVL_W-1:0] level_out;
  logic [bet_pkg::POS_W-1:0]        entry_x;
  logic [bet_pkg::POS_W-1:0]        entry_end;
  logic [bet_pkg::CNT_OUT_W-1:0]    measure_count;
  logic [bet_pkg::CNT_OUT_W-1:0]    point_count;

  modport source (output valid, status, level_out, entry_x, entry_end, measure_count,
                  point_count, input ready);
  modport sink (input valid, status, level_out, entry_x, entry_end, measure_count,
                point_count, output ready);
endinterface

### rtl/bet_cfg_if.sv
interface bet_cfg_if;
  logic valid;
  logic ready;
  logic interp_en;

  modport source (output valid, interp_en, input ready);
  modport sink (input valid, interp_en, output ready);
endinterface

### rtl/bet_ctrl.sv
module bet_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bet_pkg::dp_sts_t  sts,
  output bet_pkg::ctl_cmd_t cmd
);

  bet_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bet_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == bet_pkg::ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = bet_pkg::DP_NONE;
    cmd.load_out = 1'b0;
    unique case (state_r)
      bet_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = bet_pkg::DP_ACCEPT;
          state_nxt = bet_pkg::ST_DISPATCH;
        end
      end
      bet_pkg::ST_DISPATCH: begin
        priority if (sts.req_type == bet_pkg::REQ_APPEND) begin
          state_nxt = sts.full ? bet_pkg::ST_DONE : bet_pkg::ST_APP_PL;
        end else if (sts.req_type == bet_pkg::REQ_EVAL) begin
          state_nxt = bet_pkg::ST_SCAN;
        end else if (sts.req_type == bet_pkg::REQ_READ) begin
          state_nxt = sts.rd_ok ? bet_pkg::ST_RD_IDX : bet_pkg::ST_DONE;
        end else begin
          state_nxt = bet_pkg::ST_DONE;
        end
      end
      bet_pkg::ST_APP_PL: begin
        cmd.op    = bet_pkg::DP_APP_PL;
        state_nxt = bet_pkg::ST_APP_END;
      end
      bet_pkg::ST_APP_END: begin
        cmd.op    = bet_pkg::DP_APP_END;
        state_nxt = bet_pkg::ST_DONE;
      end
      bet_pkg::ST_SCAN: begin
        cmd.op = bet_pkg::DP_SCAN;
        if (sts.scan_done) begin
          state_nxt = sts.scan_div ? bet_pkg::ST_MUL : bet_pkg::ST_DONE;
        end
      end
      bet_pkg::ST_MUL: begin
        cmd.op    = bet_pkg::DP_MUL;
        state_nxt = bet_pkg::ST_DIV;
      end
      bet_pkg::ST_DIV: begin
        cmd.op = bet_pkg::DP_DIV;
        if (sts.div_last) begin
          state_nxt = bet_pkg::ST_INTERP;
        end
      end
      bet_pkg::ST_INTERP: begin
        cmd.op    = bet_pkg::DP_INTERP;
        state_nxt = bet_pkg::ST_DONE;
      end
      bet_pkg::ST_RD_IDX: begin
        cmd.op    = bet_pkg::DP_RD_IDX;
        state_nxt = bet_pkg::ST_RD_NEXT;
      end
      bet_pkg::ST_RD_NEXT: begin
        cmd.op    = bet_pkg::DP_RD_NEXT;
        state_nxt = bet_pkg::ST_RD_FIN;
      end
      bet_pkg::ST_RD_FIN: begin
        cmd.op    = bet_pkg::DP_RD_FIN;
        state_nxt = bet_pkg::ST_DONE;
      end
      bet_pkg::ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = bet_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bet_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/bet_datapath.sv
module bet_datapath #(
  parameter int TABLE_DEPTH   = 256,
  parameter int POS_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bet_pkg::ctl_cmd_t                   cmd,
  output bet_pkg::dp_sts_t                    sts,
  input  logic                                cfg_we,
  input  logic                                cfg_mode,
  input  logic [bet_pkg::REQ_W-1:0]           in_req_type,
  input  logic [bet_pkg::POS_W-1:0]           in_pos_x,
  input  logic signed [bet_pkg::LVL_W-1:0]    in_level_in,
  input  logic                                in_has_end,
  input  logic [bet_pkg::POS_W-1:0]           in_end_in,
  input  logic [bet_pkg::IDX_W-1:0]           in_entry_index,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                out_status,
  output logic signed [bet_pkg::LVL_W-1:0]    out_level_out,
  output logic [bet_pkg::POS_W-1:0]           out_entry_x,
  output logic [bet_pkg::POS_W-1:0]           out_entry_end,
  output logic [bet_pkg::CNT_OUT_W-1:0]       out_measure_count,
  output logic [bet_pkg::CNT_OUT_W-1:0]       out_point_count
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int KW    = $clog2(TABLE_DEPTH + 2);
  localparam int PW    = bet_pkg::POS_W;
  localparam int LW    = bet_pkg::LVL_W;
  localparam int EW    = bet_pkg::END_W;
  localparam int SW    = bet_pkg::SPAN_W;
  localparam int MW    = bet_pkg::PROD_W;
  localparam int DW    = bet_pkg::DCNT_W;
  localparam int PLW   = PW + LW;
  localparam logic [PW-1:0] FRAC_ONES = PW'((64'd1 << POS_FRAC_BITS) - 64'd1);

  // Position and level share one memory; the end flag and end live in another
  // so that trimming the previous entry touches only the end memory.
  logic [PLW-1:0] pl_mem  [TABLE_DEPTH];
  logic [EW-1:0]  end_mem [TABLE_DEPTH];

  logic                 mode_r;
  logic [bet_pkg::REQ_W-1:0] type_r;
  logic [PW-1:0]        x_r, endv_r;
  logic signed [LW-1:0] lvl_r;
  logic                 hend_r;
  logic [bet_pkg::IDX_W-1:0] idx_r;

  logic [CW-1:0]        count_r;
  logic [PW-1:0]        last_pos_r;
  logic [EW-1:0]        last_end_r;

  logic [PLW-1:0]       rpl_r;
  logic [EW-1:0]        rend_r;
  logic [KW-1:0]        k_r, dk_r;
  logic                 dvalid_r;
  logic [PW-1:0]        ppos_r;
  logic signed [LW-1:0] plvl_r;

  logic [PW-1:0]        dx_r, den_r;
  logic [SW-1:0]        span_r;
  logic signed [LW-1:0] y0_r;
  logic                 dec_r;
  logic [MW-1:0]        num_r;
  logic [PW-1:0]        rem_r;
  logic [DW-1:0]        dcnt_r;

  logic                 res_status_r;
  logic signed [LW-1:0] res_lvl_r;
  logic [PW-1:0]        res_ex_r, res_ee_r;
  logic                 rd_pend_r;

  logic                 out_valid_r;
  logic                 out_status_r;
  logic signed [LW-1:0] out_lvl_r;
  logic [PW-1:0]        out_ex_r, out_ee_r;
  logic [bet_pkg::CNT_OUT_W-1:0] out_meas_r, out_cnt_r;

  logic [AW-1:0]        rd_addr, wr_addr;
  logic                 end_we;
  logic [EW-1:0]        end_wd, trim_end, new_end;
  logic [PW-1:0]        rpos;
  logic signed [LW-1:0] rlvl;
  logic                 data_in, exhausted, step_hit, pair_hit, hit, needs_div;
  logic                 full, rd_ok, has_next;
  logic [PW:0]          trial;
  logic                 ge;
  logic [LW+1:0]        interp_sum;
  logic [PW-1:0]        meas_src, meas_full;

  assign rpos = rpl_r[PLW-1:LW];
  assign rlvl = rpl_r[LW-1:0];

  assign full     = (count_r == CW'(TABLE_DEPTH));
  assign rd_ok    = (16'(idx_r) < 16'(count_r));
  assign has_next = ((16'(idx_r) + 16'd1) < 16'(count_r));

  assign trim_end = (last_end_r[PW] && (last_end_r[PW-1:0] >= x_r))
                  ? ((x_r == '0) ? '0 : {1'b1, x_r - PW'(1)})
                  : last_end_r;
  assign new_end  = hend_r ? {1'b1, endv_r} : '0;

  always_comb begin
    unique case (cmd.op)
      bet_pkg::DP_SCAN:    rd_addr = k_r[AW-1:0];
      bet_pkg::DP_RD_IDX:  rd_addr = AW'(idx_r);
      bet_pkg::DP_RD_NEXT: rd_addr = AW'({1'b0, idx_r} + 9'd1);
      default:             rd_addr = '0;
    endcase
  end

  always_comb begin
    end_we  = 1'b0;
    wr_addr = count_r[AW-1:0];
    end_wd  = new_end;
    unique case (cmd.op)
      bet_pkg::DP_APP_PL: begin
        end_we  = (count_r != '0);
        wr_addr = AW'(count_r - CW'(1));
        end_wd  = trim_end;
      end
      bet_pkg::DP_APP_END: begin
        end_we = 1'b1;
      end
      default: begin
        end_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == bet_pkg::DP_APP_PL) begin
      pl_mem[count_r[AW-1:0]] <= {x_r, lvl_r};
    end
    if (end_we) begin
      end_mem[wr_addr] <= end_wd;
    end
    rpl_r  <= pl_mem[rd_addr];
    rend_r <= end_mem[rd_addr];
  end

  // Scan compare. In envelope mode the registered entry is the right-hand point
  // of a pair and the previous one is held in ppos_r/plvl_r.
  assign data_in   = dvalid_r && (dk_r < KW'(count_r));
  assign exhausted = dvalid_r && !data_in;
  assign step_hit  = (x_r >= rpos) && (!rend_r[PW] || (x_r <= rend_r[PW-1:0]));
  assign pair_hit  = (dk_r != '0) && (x_r >= ppos_r) && (x_r <= rpos);
  assign hit       = data_in && (mode_r ? pair_hit : step_hit);
  assign needs_div = mode_r && (x_r != ppos_r) && (x_r != rpos);

  assign trial = {rem_r, num_r[MW-1]};
  assign ge    = (trial >= {1'b0, den_r});

  assign interp_sum = dec_r ? ((LW+2)'(y0_r) - (LW+2)'({1'b0, num_r[SW-1:0]}))
                            : ((LW+2)'(y0_r) + (LW+2)'({1'b0, num_r[SW-1:0]}));

  assign meas_src  = last_end_r[PW] ? last_end_r[PW-1:0] : last_pos_r;
  assign meas_full = (meas_src >> POS_FRAC_BITS) + PW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b1;
      count_r     <= '0;
      dvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_mode;
      end
      if (cmd.op == bet_pkg::DP_ACCEPT) begin
        dvalid_r <= 1'b0;
      end else if (cmd.op == bet_pkg::DP_SCAN) begin
        dvalid_r <= 1'b1;
      end
      if (cmd.op == bet_pkg::DP_APP_END) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      bet_pkg::DP_ACCEPT: begin
        type_r       <= in_req_type;
        x_r          <= in_pos_x;
        lvl_r        <= in_level_in;
        hend_r       <= in_has_end;
        endv_r       <= in_end_in;
        idx_r        <= in_entry_index;
        k_r          <= '0;
        res_status_r <= 1'b1;
        res_lvl_r    <= '0;
        res_ex_r     <= '0;
        res_ee_r     <= '0;
        rd_pend_r    <= 1'b0;
      end
      bet_pkg::DP_APP_PL: begin
        last_end_r <= trim_end;
      end
      bet_pkg::DP_APP_END: begin
        last_pos_r   <= x_r;
        last_end_r   <= new_end;
        res_status_r <= 1'b0;
      end
      bet_pkg::DP_SCAN: begin
        k_r  <= k_r + KW'(1);
        dk_r <= k_r;
        if (dvalid_r) begin
          ppos_r <= rpos;
          plvl_r <= rlvl;
        end
        if (hit) begin
          if (!needs_div) begin
            res_status_r <= 1'b0;
            res_lvl_r    <= (mode_r && (x_r == ppos_r)) ? plvl_r : rlvl;
          end
          dx_r   <= x_r - ppos_r;
          den_r  <= rpos - ppos_r;
          y0_r   <= plvl_r;
          dec_r  <= (plvl_r > rlvl);
          span_r <= (plvl_r > rlvl) ? (SW'(plvl_r) - SW'(rlvl)) : (SW'(rlvl) - SW'(plvl_r));
        end
      end
      bet_pkg::DP_MUL: begin
        num_r  <= MW'(dx_r) * MW'(span_r);
        rem_r  <= '0;
        dcnt_r <= '0;
      end
      bet_pkg::DP_DIV: begin
        rem_r  <= ge ? PW'(trial - {1'b0, den_r}) : PW'(trial);
        num_r  <= {num_r[MW-2:0], ge};
        dcnt_r <= dcnt_r + DW'(1);
      end
      bet_pkg::DP_INTERP: begin
        res_status_r <= 1'b0;
        res_lvl_r    <= interp_sum[LW-1:0];
      end
      bet_pkg::DP_RD_NEXT: begin
        res_status_r <= 1'b0;
        res_ex_r     <= rpos;
        res_lvl_r    <= rlvl;
        priority if (rend_r[PW]) begin
          res_ee_r <= rend_r[PW-1:0];
        end else if (has_next) begin
          rd_pend_r <= 1'b1;
        end else begin
          res_ee_r <= rpos | FRAC_ONES;
        end
      end
      bet_pkg::DP_RD_FIN: begin
        if (rd_pend_r) begin
          res_ee_r <= (rpos == '0) ? '0 : (rpos - PW'(1));
        end
      end
      default: begin
        res_status_r <= res_status_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_lvl_r    <= res_lvl_r;
      out_ex_r     <= res_ex_r;
      out_ee_r     <= res_ee_r;
      out_meas_r   <= (count_r == '0) ? '0 : meas_full[bet_pkg::CNT_OUT_W-1:0];
      out_cnt_r    <= bet_pkg::CNT_OUT_W'(count_r);
    end
  end

  assign sts.req_type  = type_r;
  assign sts.full      = full;
  assign sts.rd_ok     = rd_ok;
  assign sts.scan_done = hit || exhausted;
  assign sts.scan_div  = hit && needs_div;
  assign sts.div_last  = (dcnt_r == DW'(bet_pkg::DIV_STEPS - 1));
  assign sts.out_busy  = out_valid_r && !out_ready;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_level_out     = out_lvl_r;
  assign out_entry_x       = out_ex_r;
  assign out_entry_end     = out_ee_r;
  assign out_measure_count = out_meas_r;
  assign out_point_count   = out_cnt_r;

endmodule

### rtl/breakpoint_envelope_table.sv
// Per request: append writes the point, then the end; read fetches the entry and the next
// one; evaluate scans the table, then does one multiply and a 41-step divider when the
// query falls strictly between two points with interp_en set.
// One request at a time; the next is taken once the result enters the output register.
// rst_n (synchronous, active low) empties the table and sets interp_en to 1.
module breakpoint_envelope_table #(
  parameter int TABLE_DEPTH   = 256,
  parameter int POS_FRAC_BITS = 16
) (
  input logic        clk,
  input logic        rst_n,
  bet_in_if.sink     in_ch,
  bet_out_if.source  out_ch,
  bet_cfg_if.sink    cfg_ch
);

  bet_pkg::ctl_cmd_t cmd;
  bet_pkg::dp_sts_t  sts;
  logic              in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  bet_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bet_datapath #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_ch.valid),
    .cfg_mode          (cfg_ch.interp_en),
    .in_req_type       (in_ch.req_type),
    .in_pos_x          (in_ch.pos_x),
    .in_level_in       (in_ch.level_in),
    .in_has_end        (in_ch.has_end),
    .in_end_in         (in_ch.end_in),
    .in_entry_index    (in_ch.entry_index),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_status        (out_ch.status),
    .out_level_out     (out_ch.level_out),
    .out_entry_x       (out_ch.entry_x),
    .out_entry_end     (out_ch.entry_end),
    .out_measure_count (out_ch.measure_count),
    .out_point_count   (out_ch.point_count)
  );

endmodule

### rtl/bet_checker.sv
`include "breakpoint_envelope_table_assert.svh"

module bet_checker #(
  parameter int TABLE_DEPTH = 256
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                status,
  input logic signed [bet_pkg::LVL_W-1:0]    level_out,
  input logic [bet_pkg::POS_W-1:0]           entry_x,
  input logic [bet_pkg::POS_W-1:0]           entry_end,
  input logic [bet_pkg::CNT_OUT_W-1:0]       measure_count,
  input logic [bet_pkg::CNT_OUT_W-1:0]       point_count
);

  logic [1+bet_pkg::LVL_W+2*bet_pkg::POS_W+2*bet_pkg::CNT_OUT_W-1:0] out_bus;

  assign out_bus = {status, level_out, entry_x, entry_end, measure_count, point_count};

  // A result that is not taken stays put.
  `BET_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_bus), "result changed while stalled")

  // Requests are worked one at a time, so an accepted request closes the input.
  `BET_ASSERT_NXT(a_one_request, clk, rst_n, in_valid && in_ready, !in_ready, "input open right after a request")

  `BET_ASSERT_IMP(a_count_bound, clk, rst_n, out_valid, 16'(point_count) <= 16'(TABLE_DEPTH), "point count beyond table depth")

  // An empty table has no measures.
  `BET_ASSERT_IMP(a_empty_measure, clk, rst_n, out_valid && (point_count == '0) && (TABLE_DEPTH < 512), measure_count == '0, "measures reported for an empty table")

endmodule

bind breakpoint_envelope_table bet_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_bet_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status        (out_ch.status),
  .level_out     (out_ch.level_out),
  .entry_x       (out_ch.entry_x),
  .entry_end     (out_ch.entry_end),
  .measure_count (out_ch.measure_count),
  .point_count   (out_ch.point_count)
);

### verif/bet_tb_if.sv
package bet_tb_pkg;

  // Request code that the block does not define.
  localparam logic [bet_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [bet_pkg::REQ_W-1:0]        req_type;
    logic [bet_pkg::POS_W-1:0]        pos_x;
    logic signed [bet_pkg::LVL_W-1:0] level_in;
    logic                             has_end;
    logic [bet_pkg::POS_W-1:0]        end_in;
    logic [bet_pkg::IDX_W-1:0]        entry_index;
  } bet_req_t;

  typedef struct packed {
    logic                             status;
    logic signed [bet_pkg::LVL_W-1:0] level_out;
    logic [bet_pkg::POS_W-1:0]        entry_x;
    logic [bet_pkg::POS_W-1:0]        entry_end;
    logic [bet_pkg::CNT_OUT_W-1:0]    measure_count;
    logic [bet_pkg::CNT_OUT_W-1:0]    point_count;
  } bet_rsp_t;
endpackage

### verif/tb_top.sv
module tb_top;

  localparam int DEPTH = 256;
  localparam int FRAC = 16;
  localparam int STALL_LIMIT = 20000;
  localparam int PW = bet_pkg::POS_W;
  localparam int LW = bet_pkg::LVL_W;
  localparam int CW = bet_pkg::CNT_OUT_W;

  // Scoreboard: a shadow copy of the breakpoint table predicts every result.
  class envelope_scoreboard;
    logic [PW-1:0]        pos_tbl[DEPTH];
    int                   lvl_tbl[DEPTH];
    logic                 endf_tbl[DEPTH];
    logic [PW-1:0]        end_tbl[DEPTH];
    int                   count;
    bit                   interp_mode;
    bet_tb_pkg::bet_rsp_t pending[$];
    int                   errors;

    function new();
      count = 0;
      interp_mode = 1'b1;
      errors = 0;
    endfunction

    function int blend(longint x, longint p0, int y0, longint p1, int y1);
      int lo, hi, y;
      longint off;
      if (x <= p0) return y0;
      if (x >= p1) return y1;
      lo = (y0 < y1) ? y0 : y1;
      hi = (y0 < y1) ? y1 : y0;
      off = ((x - p0) * longint'(hi - lo)) / (p1 - p0);
      y = (y0 > y1) ? y0 - int'(off) : y0 + int'(off);
      if (y < lo) y = lo;
      else if (y > hi) y = hi;
      return y;
    endfunction

    function void note_request(bet_tb_pkg::bet_req_t r);
      bet_tb_pkg::bet_rsp_t o;
      logic [PW-1:0] v, e;
      int lvl;
      int idx;
      o = '0;
      o.status = 1'b1;
      lvl = 0;
      idx = int'(r.entry_index);
      if (r.req_type == bet_pkg::REQ_APPEND) begin
        if (count < DEPTH) begin
          if (count > 0 && endf_tbl[count-1] && end_tbl[count-1] >= r.pos_x) begin
            if (r.pos_x == '0) begin
              endf_tbl[count-1] = 1'b0;
              end_tbl[count-1] = '0;
            end else begin
              end_tbl[count-1] = r.pos_x - PW'(1);
            end
          end
          pos_tbl[count] = r.pos_x;
          lvl_tbl[count] = int'(r.level_in);
          endf_tbl[count] = r.has_end;
          end_tbl[count] = r.has_end ? r.end_in : '0;
          count++;
          o.status = 1'b0;
        end
      end else if (r.req_type == bet_pkg::REQ_EVAL) begin
        for (int k = 0; k < count; k++) begin
          if (r.pos_x < pos_tbl[k]) continue;
          if (!interp_mode) begin
            e = endf_tbl[k] ? end_tbl[k] : r.pos_x;
            if (r.pos_x <= e) begin
              lvl = lvl_tbl[k];
              o.status = 1'b0;
              break;
            end
          end else begin
            if (k + 1 >= count) break;
            if (r.pos_x <= pos_tbl[k+1]) begin
              lvl = blend(longint'(r.pos_x), longint'(pos_tbl[k]), lvl_tbl[k],
                          longint'(pos_tbl[k+1]), lvl_tbl[k+1]);
              o.status = 1'b0;
              break;
            end
          end
        end
      end else if (r.req_type == bet_pkg::REQ_READ) begin
        if (idx < count) begin
          o.status = 1'b0;
          o.entry_x = pos_tbl[idx];
          lvl = lvl_tbl[idx];
          if (endf_tbl[idx]) o.entry_end = end_tbl[idx];
          else if (idx + 1 < count)
            o.entry_end = (pos_tbl[idx+1] == '0) ? '0 : pos_tbl[idx+1] - PW'(1);
          else o.entry_end = {o.entry_x[PW-1:FRAC], {FRAC{1'b1}}};
        end
      end
      o.level_out = lvl[LW-1:0];
      if (count > 0) begin
        v = endf_tbl[count-1] ? end_tbl[count-1] : pos_tbl[count-1];
        o.measure_count = CW'((v >> FRAC) + PW'(1));
      end
      o.point_count = CW'(count);
      pending.insert(pending.size(), o);
    endfunction

    function void check_result(bet_tb_pkg::bet_rsp_t got);
      bet_tb_pkg::bet_rsp_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, got %p", exp_r, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  always #5 clk = ~clk;

  bet_in_if  in_ch();
  bet_out_if out_ch();
  bet_cfg_if cfg_ch();

  breakpoint_envelope_table dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  envelope_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 0;
  int quiet_cycles = 0;

  // Result side: random stalls, plus a long hold-off when asked.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.status, out_ch.level_out, out_ch.entry_x, out_ch.entry_end,
                       out_ch.measure_count, out_ch.point_count});
    out_ch.ready <= rst_n && !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // The request stays valid after its accept until the next one is offered or
  // the sender goes idle, so valid is written once per clock edge.
  task automatic send_request(bet_tb_pkg::bet_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= r.req_type;
    in_ch.pos_x <= r.pos_x;
    in_ch.level_in <= r.level_in;
    in_ch.has_end <= r.has_end;
    in_ch.end_in <= r.end_in;
    in_ch.entry_index <= r.entry_index;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(r);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode(bit m);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.interp_en <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.interp_mode = m;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic bet_tb_pkg::bet_req_t make_req(logic [bet_pkg::REQ_W-1:0] t,
                                                    logic [PW-1:0] x, int lvl, bit he,
                                                    logic [PW-1:0] e, int idx);
    bet_tb_pkg::bet_req_t r;
    r.req_type = t;
    r.pos_x = x;
    r.level_in = lvl[LW-1:0];
    r.has_end = he;
    r.end_in = e;
    r.entry_index = idx[bet_pkg::IDX_W-1:0];
    return r;
  endfunction

  // Mostly growing positions with random content; some reversed or odd items.
  function automatic bet_tb_pkg::bet_req_t random_req(ref logic [PW-1:0] cursor);
    int kind;
    logic [PW-1:0] x;
    kind = int'($urandom_range(99));
    if (kind < 35) begin
      x = ($urandom_range(9) == 0) ? PW'($urandom) : cursor + PW'($urandom_range(200000));
      cursor = x;
      return make_req(bet_pkg::REQ_APPEND, x, int'($urandom), 1'($urandom_range(1)),
                      ($urandom_range(3) == 0) ? PW'($urandom)
                                               : x + PW'($urandom_range(300000)), 0);
    end else if (kind < 75) begin
      return make_req(bet_pkg::REQ_EVAL,
                      ($urandom_range(4) == 0) ? PW'($urandom)
                                               : PW'($urandom_range(32'(cursor))),
                      int'($urandom), 1'($urandom_range(1)), PW'($urandom),
                      int'($urandom));
    end else if (kind < 97) begin
      return make_req(bet_pkg::REQ_READ, PW'($urandom), int'($urandom),
                      1'($urandom_range(1)), PW'($urandom),
                      int'($urandom_range(sb.count + 3)));
    end
    return make_req(bet_tb_pkg::REQ_UNUSED, PW'($urandom), int'($urandom),
                    1'($urandom_range(1)), PW'($urandom), int'($urandom));
  endfunction

  initial begin
    logic [PW-1:0] cursor;
    in_ch.valid <= 1'b0;
    in_ch.req_type <= '0;
    in_ch.pos_x <= '0;
    in_ch.level_in <= '0;
    in_ch.has_end <= 1'b0;
    in_ch.end_in <= '0;
    in_ch.entry_index <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.interp_en <= 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty table, trims, zero trim, end before position, extremes.
    send_request(make_req(bet_pkg::REQ_EVAL, 24'h010000, 0, 1'b0, '0, 0));
    send_request(make_req(bet_pkg::REQ_READ, '0, 0, 1'b0, '0, 0));
    send_request(make_req(bet_pkg::REQ_APPEND, '0, -32768, 1'b1, 24'h050000, 0));
    send_request(make_req(bet_pkg::REQ_APPEND, 24'h020000, 32767, 1'b1, 24'h010000, 0));
    send_request(make_req(bet_pkg::REQ_APPEND, 24'h040000, 100, 1'b0, '0, 0));
    send_request(make_req(bet_pkg::REQ_EVAL, 24'h01_2345, 0, 1'b0, '0, 0));
    send_request(make_req(bet_pkg::REQ_EVAL, 24'h03_0000, 0, 1'b0, '0, 0));
    send_request(make_req(bet_pkg::REQ_EVAL, 24'h04_0000, 0, 1'b0, '0, 0));
    send_request(make_req(bet_pkg::REQ_EVAL, 24'hFFFFFF, 0, 1'b0, '0, 0));
    for (int i = 0; i < 4; i++) send_request(make_req(bet_pkg::REQ_READ, '0, 0, 1'b0, '0, i));
    send_request(make_req(bet_pkg::REQ_APPEND, '0, -1, 1'b1, 24'hFFFFFF, 0));
    send_request(make_req(bet_pkg::REQ_APPEND, '0, 5, 1'b0, '0, 0));
    send_request(make_req(bet_pkg::REQ_READ, '0, 0, 1'b0, '0, 3));
    send_request(make_req(bet_pkg::REQ_READ, '0, 0, 1'b0, '0, 4));
    send_request(make_req(bet_pkg::REQ_APPEND, 24'hFFFFFF, 1, 1'b1, 24'hFFFFFF, 0));
    send_request(make_req(bet_tb_pkg::REQ_UNUSED, 24'hFFFFFF, -1, 1'b1, 24'hFFFFFF, 255));
    write_mode(1'b0);
    send_request(make_req(bet_pkg::REQ_EVAL, 24'h01_8000, 0, 1'b0, '0, 0));
    send_request(make_req(bet_pkg::REQ_EVAL, '0, 0, 1'b0, '0, 0));
    send_request(make_req(bet_pkg::REQ_EVAL, 24'hFFFFFF, 0, 1'b0, '0, 0));
    write_mode(1'b1);

    cursor = 24'h040000;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      if (ph == 2) begin
        fork
          begin
            hold_off = 1;
            repeat (400) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      for (int i = 0; i < 90; i++) send_request(random_req(cursor));
      if (ph == 1) drain();
      write_mode(ph[0]);
    end

    // Fill the table to see the full-table error.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (sb.count < DEPTH)
      send_request(make_req(bet_pkg::REQ_APPEND, cursor + PW'(sb.count), int'($urandom),
                            1'b0, '0, 0));
    send_request(make_req(bet_pkg::REQ_APPEND, 24'h000001, 1, 1'b1, 24'h000002, 0));
    send_request(make_req(bet_pkg::REQ_READ, '0, 0, 1'b0, '0, 255));
    for (int i = 0; i < 20; i++) send_request(random_req(cursor));
    write_mode(1'b0);
    for (int i = 0; i < 20; i++) send_request(random_req(cursor));

    drain();
    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end
endmodule

### sim.f
+incdir+rtl
rtl/bet_pkg.sv
rtl/bet_in_if.sv
rtl/bet_out_if.sv
rtl/bet_cfg_if.sv
rtl/bet_ctrl.sv
rtl/bet_datapath.sv
rtl/breakpoint_envelope_table.sv
rtl/bet_checker.sv
verif/bet_tb_if.sv
verif/tb_top.sv
